@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file ssc_checker.
// Every check runs on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/ssc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and the ASCII case fold for the substring search.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int MaxPattern = 64;
  localparam int ByteW      = 8;
  localparam int IdxW       = $clog2(MaxPattern);
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 7;

  // Input action codes
  localparam logic ActLoad = 1'b0;
  localparam logic ActData = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIgnoreCase    = 1'b1;

  localparam logic [ByteW-1:0] AsciiUpperA = 8'h41;
  localparam logic [ByteW-1:0] AsciiUpperZ = 8'h5A;
  localparam logic [ByteW-1:0] CaseOffset  = 8'h20;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [MaxPattern-1:0] window_t;
  typedef logic [LenW-1:0] len_t;

  // Control group for the window compare
  typedef struct packed {
    len_t len;
    logic ignore_case;
  } cmp_ctrl_t;

  // Fold A-Z to a-z when case is ignored
  function automatic byte_t fold_byte(input byte_t b, input logic ic);
    byte_t r;
    r = b;
    if (ic && (b >= AsciiUpperA) && (b <= AsciiUpperZ)) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ssc_window_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_window_cmp
// Compares the newest len window bytes against the pattern in one pass.
// ----------------------------------------------------------------------------
module ssc_window_cmp import ssc_pkg::*; (
  input  window_t   window,   // element 0 is the newest byte
  input  window_t   pattern,  // element k is pattern byte k
  input  cmp_ctrl_t ctrl,
  output logic      hit
);

  window_t             rev_pat;
  window_t             aligned;
  logic [IdxW-1:0]     shift;
  logic [MaxPattern-1:0] eq;

  // Reverse the pattern so pattern byte len-1 lands next to the newest byte
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      rev_pat[i] = pattern[MaxPattern-1-i];
    end
  end

  // Align by a byte barrel shift of MaxPattern - len
  assign shift   = IdxW'(len_t'(MaxPattern) - ctrl.len);
  assign aligned = window_t'(rev_pat >> {shift, 3'b000});

  // Compare each position; positions beyond len always agree
  always_comb begin
    for (int d = 0; d < MaxPattern; d++) begin
      eq[d] = (fold_byte(window[d], ctrl.ignore_case) ==
               fold_byte(aligned[d], ctrl.ignore_case)) ||
              (len_t'(d) >= ctrl.len);
    end
  end

  assign hit = &eq;

endmodule

@@ hw/rtl/substring_search_casefold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_casefold
// Streams block bytes through a window and reports whether a pattern occurs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item. action 0
//   writes byte_value into pattern position pattern_index; action 1 shifts
//   byte_value into the data window. The data beat with last_of_block set
//   closes the block and produces one output beat (matched).
//   Output channel (out_valid/out_ready) returns matched for each block.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 =
//   pattern_length, 1 = ignore_case); write only while no beat is in flight.
// Timing:
//   One beat is taken every cycle unless a final data beat is held for a
//   waiting result. A beat sits in the input register, where the
//   full-window compare and state update run, and the result is then
//   registered in the output register once that register is free.
//   The single window compare sets the rate.
// Reset: clears the block state and both valid flags, pattern_length to 0,
//   ignore_case to 1. Pattern bytes are undefined until loaded.
// Stall: with a result waiting, load and non-final data beats still flow;
//   a final data beat waits in the input register until the output frees.
// ----------------------------------------------------------------------------
module substring_search_casefold import ssc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [IdxW-1:0]     pattern_index,
  input  logic [ByteW-1:0]    byte_value,
  input  logic                last_of_block,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                matched,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration
  logic [CfgDataW-1:0] pattern_length;
  logic                ignore_case;

  // Input register
  logic            s1_valid;
  logic            s1_action;
  logic [IdxW-1:0] s1_index;
  byte_t           s1_byte;
  logic            s1_last;

  // Block state
  window_t pattern_store;
  window_t window;
  len_t    bytes_seen;
  logic    found_flag;

  logic      s1_result;
  logic      s1_fire;
  window_t   window_next;
  len_t      seen_next;
  len_t      len_act;
  cmp_ctrl_t cmp_ctrl;
  logic      cmp_hit;
  logic      found_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      ignore_case    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgPatternLength: pattern_length <= cfg_data;
        CfgIgnoreCase:    ignore_case    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Handshake: the input register drains unless a result beat is blocked
  assign s1_result = s1_valid && (s1_action == ActData) && s1_last;
  assign s1_fire   = s1_valid && (!s1_result || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_index  <= pattern_index;
      s1_byte   <= byte_value;
      s1_last   <= last_of_block;
    end
  end

  // Clamp the length to the store depth
  assign len_act = (pattern_length > CfgDataW'(MaxPattern)) ? len_t'(MaxPattern)
                                                             : len_t'(pattern_length);

  // Shifted window and saturating byte count
  assign window_next = {window[MaxPattern-2:0], s1_byte};
  assign seen_next   = (bytes_seen < len_t'(MaxPattern)) ? bytes_seen + len_t'(1)
                                                         : bytes_seen;

  assign cmp_ctrl.len         = len_act;
  assign cmp_ctrl.ignore_case = ignore_case;

  ssc_window_cmp u_cmp (
    .window  (window_next),
    .pattern (pattern_store),
    .ctrl    (cmp_ctrl),
    .hit     (cmp_hit)
  );

  assign found_next = found_flag || (len_act == '0) ||
                      ((seen_next >= len_act) && cmp_hit);

  // Load pattern bytes
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_action == ActLoad)) begin
      pattern_store[s1_index] <= s1_byte;
    end
  end

  // Advance the window; bytes older than the block are masked by bytes_seen
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_action == ActData)) begin
      window <= window_next;
    end
  end

  // Update block state, drop it at block end
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      found_flag <= 1'b0;
    end else if (s1_fire && (s1_action == ActData)) begin
      if (s1_last) begin
        bytes_seen <= '0;
        found_flag <= 1'b0;
      end else begin
        bytes_seen <= seen_next;
        found_flag <= found_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      matched <= found_next;
    end
  end

endmodule

@@ hw/rtl/ssc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the substring search, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssc_checker import ssc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                action,
  input logic                last_of_block,
  input logic                out_valid,
  input logic                out_ready,
  input logic                matched
);

  logic last_beat;

  assign last_beat = in_valid && in_ready && (action == ActData) && last_of_block;

  // A stalled output beat holds
  `SSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(matched))

  // Checks that a final data beat reaches the output via the input register and then the output register
  `SSC_ASSERT_NEXT(a_last_gives_result, last_beat, ##1 out_valid)

  // Checks that a fresh output beat comes only from a final data beat that passed the input and output registers
  `SSC_ASSERT_SAME(a_result_has_source, $rose(out_valid), $past(last_beat, 2))

  // With the output empty, input is never blocked
  `SSC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind substring_search_casefold ssc_checker u_ssc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .last_of_block (last_of_block),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .matched       (matched)
);
